### design/q2e_pkg.sv
`timescale 1ns / 1ps
package q2e_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ROOT_BITS     = 29;
  localparam int XW            = 37;
  localparam int ZW            = 34;
  localparam int RW            = 59;
  localparam int PITCH_LIMIT   = 16384;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic               asin_clamped;
  } out_t;

  typedef struct packed {
    logic signed [33:0] ya;
    logic signed [33:0] xa;
    logic signed [33:0] yr;
    logic signed [33:0] xr;
    logic signed [29:0] s;
    logic               clamp;
  } aux_t;

  typedef struct packed {
    logic            valid;
    logic [RW-1:0]   rem;
    logic [ROOT_BITS-1:0] root;
    aux_t            aux;
  } root_t;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic                 tag;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // fold left half plane onto the right one, flag the zero vector
  function automatic cordic_t cordic_prep(input logic signed [XW-1:0] y,
                                          input logic signed [XW-1:0] x,
                                          input logic tag);
    cordic_t c;
    c.valid = 1'b0;
    c.tag   = tag;
    c.zero  = (x == '0) && (y == '0);
    c.x     = x;
    c.y     = y;
    c.z     = '0;
    if (x < 0) begin
      c.x = -x;
      c.y = -y;
      c.z = (y >= 0) ? (ZW'(1) <<< 31) : -(ZW'(1) <<< 31);
    end
    return c;
  endfunction

endpackage

### design/q2e_front.sv
`timescale 1ns / 1ps
module q2e_front import q2e_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  in_t   cmd_i,
  output root_t root_o
);

  logic        va_q, vb_q, vc_q, vd_q, ve_q;
  logic signed [15:0] q0_q, q1_q, q2_q, q3_q;
  logic signed [31:0] p12_q, p03_q, p00_q, p11_q, p23_q, p01_q, p33_q, p13_q, p02_q;
  aux_t        auxc_q, auxd_q, auxe_q;
  logic [28:0] mag_q;
  logic [57:0] msq_q;
  logic [56:0] rad_q;
  aux_t        aux_d;
  logic signed [33:0] s_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      va_q <= start_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_comb begin
    aux_d.ya = (34'(p12_q) - 34'(p03_q)) <<< 1;
    aux_d.xa = ((34'(p00_q) + 34'(p11_q)) <<< 1) - (34'sd1 <<< 28);
    aux_d.yr = (34'(p23_q) - 34'(p01_q)) <<< 1;
    aux_d.xr = ((34'(p00_q) + 34'(p33_q)) <<< 1) - (34'sd1 <<< 28);
    s_raw    = (34'(p13_q) + 34'(p02_q)) <<< 1;
    aux_d.clamp = 1'b0;
    aux_d.s     = s_raw[29:0];
    if (s_raw > (34'sd1 <<< 28)) begin
      aux_d.s     = 30'sd1 <<< 28;
      aux_d.clamp = 1'b1;
    end else if (s_raw < -(34'sd1 <<< 28)) begin
      aux_d.s     = -(30'sd1 <<< 28);
      aux_d.clamp = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q   <= cmd_i.quat_w[31:16];
    q1_q   <= cmd_i.quat_x[31:16];
    q2_q   <= cmd_i.quat_y[31:16];
    q3_q   <= cmd_i.quat_z[31:16];
    p12_q  <= q1_q * q2_q;
    p03_q  <= q0_q * q3_q;
    p00_q  <= q0_q * q0_q;
    p11_q  <= q1_q * q1_q;
    p23_q  <= q2_q * q3_q;
    p01_q  <= q0_q * q1_q;
    p33_q  <= q3_q * q3_q;
    p13_q  <= q1_q * q3_q;
    p02_q  <= q0_q * q2_q;
    auxc_q <= aux_d;
    mag_q  <= aux_d.s[29] ? 29'(-aux_d.s) : aux_d.s[28:0];
    auxd_q <= auxc_q;
    msq_q  <= 58'(mag_q) * 58'(mag_q);
    auxe_q <= auxd_q;
    rad_q  <= 57'((58'd1 << 56) - msq_q);
  end

  always_comb begin
    root_o.valid = ve_q;
    root_o.rem   = RW'(rad_q);
    root_o.root  = '0;
    root_o.aux   = auxe_q;
  end

endmodule

### design/q2e_root_cell.sv
`timescale 1ns / 1ps
module q2e_root_cell import q2e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [4:0] bit_i,
  input  root_t      cell_i,
  output root_t      cell_o
);

  logic          vld_q;
  root_t         dat_q, nxt;
  logic [RW-1:0] trial;

  // (root + 2^k)^2 - root^2 with root holding only bits above k
  always_comb begin
    trial = (RW'(cell_i.root) << (bit_i + 5'd1)) | (RW'(1) << (6'(bit_i) << 1));
    nxt   = cell_i;
    if (cell_i.rem >= trial) begin
      nxt.rem  = cell_i.rem - trial;
      nxt.root = cell_i.root | (ROOT_BITS'(1) << bit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= cell_i.valid;
  end

  always_ff @(posedge clk_i) begin
    dat_q <= nxt;
  end

  always_comb begin
    cell_o       = dat_q;
    cell_o.valid = vld_q;
  end

endmodule

### design/q2e_cordic_cell.sv
`timescale 1ns / 1ps
module q2e_cordic_cell import q2e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [4:0] stage_i,
  input  cordic_t    cell_i,
  output cordic_t    cell_o
);

  logic                 vld_q;
  cordic_t              dat_q, nxt;
  logic signed [XW-1:0] dx, dy;

  always_comb begin
    dx  = cell_i.x >>> stage_i;
    dy  = cell_i.y >>> stage_i;
    nxt = cell_i;
    if (cell_i.y >= 0) begin
      nxt.x = cell_i.x + dy;
      nxt.y = cell_i.y - dx;
      nxt.z = cell_i.z + atan_step(stage_i);
    end else begin
      nxt.x = cell_i.x - dy;
      nxt.y = cell_i.y + dx;
      nxt.z = cell_i.z - atan_step(stage_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= cell_i.valid;
  end

  always_ff @(posedge clk_i) begin
    dat_q <= nxt;
  end

  always_comb begin
    cell_o       = dat_q;
    cell_o.valid = vld_q;
  end

endmodule

### design/quaternion_to_euler_core.sv
`timescale 1ns / 1ps
// channel   dir  handshake        payload
// command   in   start / busy     cmd_i (in_t)
// result    out  done_o strobe    res_o (out_t)
//
// fully pipelined: one transaction per cycle, busy stays low
// pipeline stages: 5 product/square stages, 29 root
// cells (one root bit each), 1 fold stage, the cordic cells, 1 output stage
// async active-low reset clears the valid chain; payload flops are not reset
// the receiver cannot stall, so results leave on the cycle they are ready
module quaternion_to_euler_core import q2e_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  cmd_i,
  output logic done_o,
  output out_t res_o
);

  localparam int LAT = 36 + CORDIC_STAGES;

  root_t   rt [ROOT_BITS+1];
  cordic_t cy [3][CORDIC_STAGES+1];
  cordic_t prep_q [3];
  logic    prep_v_q;
  logic    done_q;
  out_t    res_q;
  logic signed [ZW-1:0] zy, zp, zr;
  logic signed [ZW:0]   nzp;
  logic signed [ZW-1:0] ry, rr;
  logic signed [ZW:0]   rp;
  logic [XW-1:0]        c_ext;

  assign busy = 1'b0;

  q2e_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .cmd_i  (cmd_i),
    .root_o (rt[0])
  );

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
    q2e_root_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .bit_i (5'(ROOT_BITS - 1 - j)),
      .cell_i(rt[j]),
      .cell_o(rt[j+1])
    );
  end

  assign c_ext = XW'(rt[ROOT_BITS].root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prep_v_q <= 1'b0;
    else         prep_v_q <= rt[ROOT_BITS].valid;
  end

  always_ff @(posedge clk_i) begin
    prep_q[0] <= cordic_prep(XW'(rt[ROOT_BITS].aux.ya), XW'(rt[ROOT_BITS].aux.xa), 1'b0);
    prep_q[1] <= cordic_prep(XW'(rt[ROOT_BITS].aux.s), $signed(c_ext),
                             rt[ROOT_BITS].aux.clamp);
    prep_q[2] <= cordic_prep(XW'(rt[ROOT_BITS].aux.yr), XW'(rt[ROOT_BITS].aux.xr), 1'b0);
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    always_comb begin
      cy[l][0]       = prep_q[l];
      cy[l][0].valid = prep_v_q;
    end
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      q2e_cordic_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .stage_i(5'(i)),
        .cell_i (cy[l][i]),
        .cell_o (cy[l][i+1])
      );
    end
  end

  // zero vector reads as angle zero; rounding is half-up, pitch is negated
  always_comb begin
    zy  = cy[0][CORDIC_STAGES].zero ? '0 : cy[0][CORDIC_STAGES].z;
    zp  = cy[1][CORDIC_STAGES].zero ? '0 : cy[1][CORDIC_STAGES].z;
    zr  = cy[2][CORDIC_STAGES].zero ? '0 : cy[2][CORDIC_STAGES].z;
    nzp = -(ZW+1)'(zp);
    ry  = (zy + ZW'(32768)) >>> 16;
    rr  = (zr + ZW'(32768)) >>> 16;
    rp  = (nzp + (ZW+1)'(32768)) >>> 16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= cy[0][CORDIC_STAGES].valid;
  end

  always_ff @(posedge clk_i) begin
    res_q.yaw_angle    <= ry[15:0];
    res_q.roll_angle   <= rr[15:0];
    res_q.asin_clamped <= cy[1][CORDIC_STAGES].tag;
    if (rp > (ZW+1)'(PITCH_LIMIT))       res_q.pitch_angle <= 16'(PITCH_LIMIT);
    else if (rp < -(ZW+1)'(PITCH_LIMIT)) res_q.pitch_angle <= -16'(PITCH_LIMIT);
    else                                 res_q.pitch_angle <= rp[15:0];
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.pitch_angle <= 16'sd16384 && res_o.pitch_angle >= -16'sd16384))
    else $error("pitch out of range");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LAT done_o)
    else $error("result missing after a command");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result without a command");

endmodule
